// ===== hdl/ckmp_pkg.sv =====
// Shared types, constants and register codes for the color key mask packer.
package ckmp_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int MAX_ROW_WIDTH = 4096;
    localparam int COLOR_WIDTH   = 32;

    localparam int PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(MAX_ROW_WIDTH);
    localparam int WID_W   = 13;
    localparam int CMP_W   = (CNT_W + 1 > WID_W) ? CNT_W + 1 : WID_W;

    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_PIXEL_MODE = 2'd0;
    localparam logic [1:0] REG_KEY_COLOR  = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd2;

    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    localparam logic MODE_DIRECT  = 1'b0;
    localparam logic MODE_INDEXED = 1'b1;

    localparam logic [7:0] FIRST_BIT = 8'd128;

    typedef struct packed {
        logic        req_type;
        logic [31:0] pixel_value;
        logic [7:0]  palette_index;
        logic [31:0] palette_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0] mask_byte;
        logic       row_end;
    } t_out_item;

    typedef struct packed {
        logic             pixel_mode;
        logic [31:0]      key_color;
        logic [WID_W-1:0] row_width;
    } t_cfg;

endpackage

// ===== hdl/ckmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ckmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ckmp_cfg.sv =====
// APB-style configuration registers for the color key mask packer.
module ckmp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ckmp_pkg::APB_AW-1:0]  paddr,
    input  logic [ckmp_pkg::APB_DW-1:0]  pwdata,
    output logic [ckmp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output ckmp_pkg::t_cfg               o_cfg
);

    ckmp_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ckmp_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_mode <= ckmp_pkg::MODE_DIRECT;
            r_cfg.key_color  <= '0;
            r_cfg.row_width  <= ckmp_pkg::WID_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                ckmp_pkg::REG_PIXEL_MODE: r_cfg.pixel_mode <= pwdata[0];
                ckmp_pkg::REG_KEY_COLOR:  r_cfg.key_color  <= pwdata;
                ckmp_pkg::REG_ROW_WIDTH:  r_cfg.row_width  <= pwdata[ckmp_pkg::WID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ckmp_pkg::REG_PIXEL_MODE: prdata = {31'd0, r_cfg.pixel_mode};
            ckmp_pkg::REG_KEY_COLOR:  prdata = r_cfg.key_color;
            ckmp_pkg::REG_ROW_WIDTH:
                prdata = {{(ckmp_pkg::APB_DW - ckmp_pkg::WID_W){1'b0}}, r_cfg.row_width};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/ckmp_packer.sv =====
// Palette lookup, key compare and mask byte packing with an output register.
module ckmp_packer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ckmp_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ckmp_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ckmp_pkg::t_out_item  o_out_data
);

    localparam int CW = ckmp_pkg::COLOR_WIDTH;

    // Stage 1: an accepted pixel waiting for its palette read.
    logic                          r_s1_valid;
    logic [31:0]                   r_s1_value;
    logic                          r_s1_idx_ok;

    logic [7:0]                    r_pending;
    logic [2:0]                    r_bitpos;
    logic [ckmp_pkg::CNT_W-1:0]    r_count;

    logic                          r_out_valid;
    ckmp_pkg::t_out_item           r_out;

    logic                          in_fire;
    logic                          pix_fire;
    logic                          pal_fire;
    logic                          s1_fire;
    logic                          pal_wr_ok;
    logic [CW-1:0]                 pal_rdata;
    logic [CW-1:0]                 color;
    logic                          match;
    logic [7:0]                    n_pending;
    logic [2:0]                    n_bitpos;
    logic [ckmp_pkg::CMP_W-1:0]    cnt_next;
    logic [ckmp_pkg::CMP_W-1:0]    row_w;
    logic [ckmp_pkg::CMP_W-1:0]    eff_w;
    logic                          row_done;
    logic                          emit;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;
    assign pix_fire   = in_fire && (i_in_data.req_type == ckmp_pkg::REQ_PIXEL);
    assign pal_fire   = in_fire && (i_in_data.req_type == ckmp_pkg::REQ_PALETTE);
    assign pal_wr_ok  = int'(i_in_data.palette_index) < ckmp_pkg::PALETTE_DEPTH;

    // A write lands at its accept edge, so a pixel accepted next cycle reads it.
    ckmp_ram #(
        .WIDTH (CW),
        .DEPTH (ckmp_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_fire && pal_wr_ok),
        .i_waddr (i_in_data.palette_index[ckmp_pkg::PAL_AW-1:0]),
        .i_wdata (i_in_data.palette_color[CW-1:0]),
        .i_re    (pix_fire),
        .i_raddr (i_in_data.pixel_value[ckmp_pkg::PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    always_comb begin
        row_w = ckmp_pkg::CMP_W'(i_cfg.row_width);
        if (row_w == '0) begin
            eff_w = ckmp_pkg::CMP_W'(1);
        end else if (row_w > ckmp_pkg::CMP_W'(ckmp_pkg::MAX_ROW_WIDTH)) begin
            eff_w = ckmp_pkg::CMP_W'(ckmp_pkg::MAX_ROW_WIDTH);
        end else begin
            eff_w = row_w;
        end

        color = (i_cfg.pixel_mode == ckmp_pkg::MODE_INDEXED) ? pal_rdata : r_s1_value[CW-1:0];
        match = (color == i_cfg.key_color[CW-1:0]) &&
                ((i_cfg.pixel_mode == ckmp_pkg::MODE_DIRECT) || r_s1_idx_ok);

        n_pending = r_pending | (match ? (ckmp_pkg::FIRST_BIT >> r_bitpos) : 8'd0);
        n_bitpos  = r_bitpos + 3'd1;
        cnt_next  = ckmp_pkg::CMP_W'(r_count) + ckmp_pkg::CMP_W'(1);
        row_done  = cnt_next >= eff_w;
        emit      = row_done || (n_bitpos == 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_pending   <= '0;
            r_bitpos    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pix_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                if (row_done) begin
                    r_pending <= '0;
                    r_bitpos  <= '0;
                    r_count   <= '0;
                end else begin
                    r_pending <= (n_bitpos == 3'd0) ? 8'd0 : n_pending;
                    r_bitpos  <= n_bitpos;
                    r_count   <= cnt_next[ckmp_pkg::CNT_W-1:0];
                end
            end

            if (s1_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_s1_value  <= i_in_data.pixel_value;
            r_s1_idx_ok <= int'(i_in_data.pixel_value[7:0]) < ckmp_pkg::PALETTE_DEPTH;
        end
        if (s1_fire && emit) begin
            r_out.mask_byte <= n_pending;
            r_out.row_end   <= row_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/color_key_mask_packer_top.sv =====
// Top level of the color key mask packer.
//
//   Channel   Direction  Handshake               Payload
//   input     in         i_in_valid/o_in_ready   t_in_item (pixel or palette write)
//   output    out        o_out_valid/i_out_ready t_out_item (mask byte, row end)
//   config    in         APB psel/penable/pready pixel_mode, key_color, row_width
//
// One request is taken per clock unless a stalled output holds the pixel
// stage, which then stalls the input. A pixel passes a palette read stage
// and then the compare and packing stage into the output register. Palette
// writes finish at their accept edge. Reset clears packing state and
// registers; the palette is not cleared.
module color_key_mask_packer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ckmp_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ckmp_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ckmp_pkg::APB_AW-1:0]  paddr,
    input  logic [ckmp_pkg::APB_DW-1:0]  pwdata,
    output logic [ckmp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    ckmp_pkg::t_cfg cfg;

    ckmp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ckmp_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
